[sv/vris_pkg.sv]
// shared types and codes for the valid range interval set
package vris_pkg;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_BADINDEX = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDWAIT,
    S_SCAN,
    S_FIN,
    S_DONE
  } eng_state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] range_start;
    logic [31:0] range_length;
    logic [4:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] entry_start;
    logic [31:0] entry_length;
    logic [5:0]  entry_count;
  } res_t;

endpackage

[sv/vris_bank.sv]
// one table bank: single write port, registered read port
module vris_bank #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int W     = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/vris_engine.sv]
// request sequencer: for an add, streams the active bank into the spare bank while merging
module vris_engine #(
  parameter int CAPACITY = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  vris_pkg::req_t req,
  output logic          req_ready,
  output logic          res_valid,
  output vris_pkg::res_t res,
  input  logic          res_take
);
  import vris_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = $clog2(CAPACITY + 2);

  eng_state_t state, state_next;

  logic          sel;
  logic [CW-1:0] count;
  logic [CW-1:0] k;
  logic [WW-1:0] w;
  logic          placed, p_valid, p_new;
  logic [31:0]   ns, ne, ps, pe, os, oe;

  // bank ports
  logic [AW-1:0] raddr, waddr;
  logic          we0, we1, wen;
  logic [63:0]   rdata0, rdata1, act_data, wdata;
  logic [31:0]   ds, de;

  // request decode
  logic [32:0]   sum33;
  logic          ovf, bad_idx;
  logic [CW+4:0] idx_cmp, cnt_cmp;
  logic [AW+4:0] idx_ext;
  logic [CW+5:0] cnt_ext, w_ext;
  status_t       idle_status;
  logic [5:0]    idle_count;

  // scan step
  logic          have_d, d_less, take_new, take_d, flush, merge, commit_p;
  logic [31:0]   el_s, el_e;
  logic [CW-1:0] k_next;
  logic          full;

  vris_bank #(.DEPTH(CAPACITY), .AW(AW), .W(64)) u_bank0 (
    .clk(clk), .we(we0), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata0)
  );
  vris_bank #(.DEPTH(CAPACITY), .AW(AW), .W(64)) u_bank1 (
    .clk(clk), .we(we1), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata1)
  );

  assign act_data = sel ? rdata1 : rdata0;
  assign ds       = act_data[63:32];
  assign de       = act_data[31:0];

  assign sum33   = {1'b0, req.range_start} + {1'b0, req.range_length};
  assign ovf     = sum33[32];
  assign idx_cmp = (CW + 5)'(req.entry_index);
  assign cnt_cmp = (CW + 5)'(count);
  assign bad_idx = idx_cmp >= cnt_cmp;
  assign idx_ext = (AW + 5)'(req.entry_index);
  assign cnt_ext = (CW + 6)'(count);
  assign w_ext   = (CW + 6)'(w);
  assign full    = w > WW'(CAPACITY);

  // status and count for a transaction taken in idle
  always_comb begin
    idle_status = ST_OK;
    if (req.req_type == REQ_ADD && ovf) begin
      idle_status = ST_OVERFLOW;
    end
    if (req.req_type == REQ_READ && bad_idx) begin
      idle_status = ST_BADINDEX;
    end
    idle_count = (req.req_type == REQ_CLEAR) ? 6'd0 : cnt_ext[5:0];
  end

  always_comb begin
    have_d   = k < count;
    d_less   = (ds < ns) || ((ds == ns) && (de < ne));
    take_new = !placed && (!have_d || !d_less);
    take_d   = have_d && !take_new;
    flush    = placed && !have_d;
    el_s     = take_new ? ns : ds;
    el_e     = take_new ? ne : de;
    merge    = p_valid && (pe >= el_s);
    commit_p = (state == S_SCAN) && p_valid && (flush || !merge);
    k_next   = k + {{(CW-1){1'b0}}, take_d};
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (req.req_type)
            REQ_ADD:  state_next = ovf ? S_DONE : S_SCAN;
            REQ_READ: state_next = bad_idx ? S_DONE : S_RDWAIT;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_RDWAIT: state_next = S_DONE;
      S_SCAN:   state_next = flush ? S_FIN : S_SCAN;
      S_FIN:    state_next = S_DONE;
      S_DONE:   state_next = res_take ? S_IDLE : S_DONE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs and bank controls
  always_comb begin
    req_ready = 1'b0;
    res_valid = 1'b0;
    raddr     = '0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        raddr     = (req.req_type == REQ_READ) ? idx_ext[AW-1:0] : '0;
      end
      S_SCAN:  raddr = k_next[AW-1:0];
      S_DONE:  res_valid = 1'b1;
      default: raddr = '0;
    endcase
  end

  assign wen   = commit_p && (w < WW'(CAPACITY));
  assign we0   = wen && sel;
  assign we1   = wen && !sel;
  assign waddr = w[AW-1:0];
  assign wdata = {ps, pe};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= 1'b0;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && req_valid && req.req_type == REQ_CLEAR) begin
        count <= '0;
      end
      if (state == S_FIN && !full) begin
        count <= w[CW-1:0];
        sel   <= ~sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        k       <= '0;
        w       <= '0;
        placed  <= 1'b0;
        p_valid <= 1'b0;
        p_new   <= 1'b0;
        ns      <= req.range_start;
        ne      <= sum33[31:0];
        res     <= '{status: idle_status, entry_start: '0, entry_length: '0,
                     entry_count: idle_count};
      end
      S_RDWAIT: begin
        res.entry_start  <= ds;
        res.entry_length <= de - ds;
      end
      S_SCAN: begin
        if (commit_p) begin
          w <= w + WW'(1);
          if (p_new) begin
            os <= ps;
            oe <= pe;
          end
        end
        if (!flush) begin
          if (merge) begin
            pe    <= (pe >= el_e) ? pe : el_e;
            p_new <= p_new | take_new;
          end else begin
            ps    <= el_s;
            pe    <= el_e;
            p_new <= take_new;
          end
          p_valid <= 1'b1;
          placed  <= placed | take_new;
          k       <= k_next;
        end
      end
      S_FIN: begin
        if (full) begin
          res.status <= ST_FULL;
        end else begin
          res.entry_start  <= os;
          res.entry_length <= oe - os;
          res.entry_count  <= w_ext[5:0];
        end
      end
      default: begin
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_take_in_done: assert property (@(posedge clk) disable iff (rst)
    res_take |-> state == S_DONE)
    else $error("result taken while none is ready");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_take) |=> state == S_IDLE)
    else $error("engine did not return to idle after delivery");

  a_swap_on_fin: assert property (@(posedge clk) disable iff (rst)
    (sel != $past(sel)) |-> $past(state) == S_FIN)
    else $error("bank select changed outside commit");

endmodule

[sv/valid_range_interval_set_top.sv]
// top level of the valid range interval set: handshakes and result register
// add: one pass over the active bank at one entry per cycle, merged copy written to
//   the spare bank, which becomes the active bank unless the table is full; read:
//   one registered bank read, skipped for a bad index; clear, unknown request and
//   overflowing add: answered straight from idle
// one transaction in flight; the next is taken once a result reaches the output register
// synchronous active-high reset empties the table; bank contents stay undefined
module valid_range_interval_set_top #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] range_start,
  input  logic [31:0] range_length,
  input  logic [4:0]  entry_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] entry_start,
  output logic [31:0] entry_length,
  output logic [5:0]  entry_count
);
  import vris_pkg::*;

  req_t req;
  res_t res, res_q;
  logic req_ready, res_valid, res_take;

  // request fields travel to the engine as one bundle
  assign req = '{req_type: req_type, range_start: range_start,
                 range_length: range_length, entry_index: entry_index};

  // engine only takes a transaction while idle
  assign in_stall = !req_ready;

  vris_engine #(.CAPACITY(CAPACITY)) u_engine (
    .clk(clk), .rst(rst),
    .req_valid(in_valid), .req(req), .req_ready(req_ready),
    .res_valid(res_valid), .res(res), .res_take(res_take)
  );

  // output register: loads when empty or when its transaction leaves this cycle
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      res_q <= res;
    end
  end

  assign status       = res_q.status;
  assign entry_start  = res_q.entry_start;
  assign entry_length = res_q.entry_length;
  assign entry_count  = res_q.entry_count;

endmodule

[test/valid_range_interval_set_top_tb.sv]
// self-checking testbench for the valid range interval set: directed and random transactions
module valid_range_interval_set_top_tb;
  import vris_pkg::*;

  localparam int CAP = 32;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RX_HOLD_CYCLES = 200;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  req_type;
  logic [31:0] range_start;
  logic [31:0] range_length;
  logic [4:0]  entry_index;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [31:0] entry_start;
  logic [31:0] entry_length;
  logic [5:0]  entry_count;

  valid_range_interval_set_top #(.CAPACITY(CAP)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .range_start(range_start),
    .range_length(range_length), .entry_index(entry_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .entry_start(entry_start),
    .entry_length(entry_length), .entry_count(entry_count)
  );

  // predictor copy of the range table
  logic [31:0] tbl_start [CAP];
  logic [31:0] tbl_len   [CAP];
  int          tbl_count;

  req_t pending_reqs[$];
  res_t expected_results[$];

  int  mismatches;
  int  sent_count;
  int  got_count;
  int  idle_cycles;
  bit  idling_on;
  bit  rx_hold;
  bit  rx_hold_done;
  bit  tx_pause;
  bit  done_stim;
  bit  in_took;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic bit ranges_touch(logic [31:0] as, logic [31:0] al,
                                      logic [31:0] bs, logic [31:0] bl);
    logic [32:0] aend;
    logic [32:0] bend;
    aend = {1'b0, as} + al;
    bend = {1'b0, bs} + bl;
    return (as <= bs && aend >= {1'b0, bs}) || (bs <= as && bend >= {1'b0, as});
  endfunction

  // apply one request to the table copy and return the result it causes
  function automatic res_t apply_request(req_t rq);
    res_t        r;
    logic [31:0] ws [CAP+1];
    logic [31:0] wl [CAP+1];
    logic [32:0] aend;
    logic [32:0] bend;
    logic [32:0] hi;
    logic [31:0] lo;
    int          n;
    int          pos;
    int          i;
    bit          found;
    r = '0;
    r.status = ST_OK;
    case (req_type_t'(rq.req_type))
      REQ_ADD: begin
        if ({1'b0, rq.range_start} + rq.range_length > 33'hFFFFFFFF) begin
          r.status = ST_OVERFLOW;
        end else begin
          n = tbl_count;
          for (i = 0; i < n; i++) begin
            ws[i] = tbl_start[i];
            wl[i] = tbl_len[i];
          end
          found = 1'b0;
          pos = 0;
          for (i = n - 1; i >= 0; i--) begin
            if (ws[i] < rq.range_start ||
                (ws[i] == rq.range_start && wl[i] < rq.range_length)) begin
              found = 1'b1;
              pos = i;
              break;
            end
          end
          if (found && ranges_touch(ws[pos], wl[pos], rq.range_start, rq.range_length)) begin
            aend = {1'b0, ws[pos]} + wl[pos];
            bend = {1'b0, rq.range_start} + rq.range_length;
            lo = (ws[pos] < rq.range_start) ? ws[pos] : rq.range_start;
            hi = (aend > bend) ? aend : bend;
            ws[pos] = lo;
            wl[pos] = 32'(hi - lo);
          end else begin
            pos = found ? pos + 1 : 0;
            for (i = n; i > pos; i--) begin
              ws[i] = ws[i-1];
              wl[i] = wl[i-1];
            end
            ws[pos] = rq.range_start;
            wl[pos] = rq.range_length;
            n++;
          end
          // absorb every following entry that overlaps or touches
          while (pos + 1 < n && ranges_touch(ws[pos], wl[pos], ws[pos+1], wl[pos+1])) begin
            aend = {1'b0, ws[pos]} + wl[pos];
            bend = {1'b0, ws[pos+1]} + wl[pos+1];
            lo = (ws[pos] < ws[pos+1]) ? ws[pos] : ws[pos+1];
            hi = (aend > bend) ? aend : bend;
            ws[pos] = lo;
            wl[pos] = 32'(hi - lo);
            for (i = pos + 1; i + 1 < n; i++) begin
              ws[i] = ws[i+1];
              wl[i] = wl[i+1];
            end
            n--;
          end
          if (n > CAP) begin
            r.status = ST_FULL;
          end else begin
            for (i = 0; i < n; i++) begin
              tbl_start[i] = ws[i];
              tbl_len[i] = wl[i];
            end
            tbl_count = n;
            r.entry_start = ws[pos];
            r.entry_length = wl[pos];
          end
        end
      end
      REQ_READ: begin
        if (rq.entry_index < tbl_count) begin
          r.entry_start = tbl_start[rq.entry_index];
          r.entry_length = tbl_len[rq.entry_index];
        end else begin
          r.status = ST_BADINDEX;
        end
      end
      REQ_CLEAR: tbl_count = 0;
      default: ;
    endcase
    r.entry_count = 6'(tbl_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d: %s got %h expected %h", got_count, what, got, want);
    mismatches++;
  endtask

  task automatic push_req(req_type_t t, logic [31:0] s, logic [31:0] l, logic [4:0] idx);
    req_t rq;
    rq.req_type = t;
    rq.range_start = s;
    rq.range_length = l;
    rq.entry_index = idx;
    pending_reqs.push_back(rq);
  endtask

  // input handshake seen at the rising edge
  always @(posedge clk) begin
    in_took <= !rst && in_valid && !in_stall;
  end

  // driver: offers queued transactions at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_took) begin
        expected_results.push_back(apply_request(pending_reqs.pop_front()));
        sent_count++;
      end
      if (in_valid && !in_took) begin
        // stalled payload holds
      end else if (tx_pause || pending_reqs.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end else begin
        in_valid <= 1'b1;
        req_type <= pending_reqs[0].req_type;
        range_start <= pending_reqs[0].range_start;
        range_length <= pending_reqs[0].range_length;
        entry_index <= pending_reqs[0].entry_index;
      end
    end
  end

  // receiver stall: random bursts, or a long hold when asked
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (rx_hold && !rx_hold_done) begin
      out_stall <= 1'b1;
      repeat (RX_HOLD_CYCLES) @(negedge clk);
      rx_hold_done = 1'b1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: compares each accepted result with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(status), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) report_mismatch("status", 32'(status), 32'(want.status));
        if (entry_start !== want.entry_start)
          report_mismatch("entry_start", entry_start, want.entry_start);
        if (entry_length !== want.entry_length)
          report_mismatch("entry_length", entry_length, want.entry_length);
        if (entry_count !== want.entry_count)
          report_mismatch("entry_count", 32'(entry_count), 32'(want.entry_count));
      end
      got_count++;
    end
  end

  // watchdog: cycles with no accepted transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", expected_results.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_word();
    return $urandom();
  endfunction

  // mixed traffic: small ranges in a window so merges and fills happen, plus random words
  task automatic queue_random(int count, logic [31:0] base);
    int k;
    int pick;
    logic [31:0] s;
    logic [31:0] l;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      s = base + $urandom_range(0, 2000);
      l = $urandom_range(0, 40);
      if (pick < 60) push_req(REQ_ADD, s, l, 5'($urandom));
      else if (pick < 80) push_req(REQ_READ, rand_word(), rand_word(), 5'($urandom));
      else if (pick < 84) push_req(REQ_CLEAR, rand_word(), rand_word(), 5'($urandom));
      else if (pick < 87) push_req(REQ_NONE, rand_word(), rand_word(), 5'($urandom));
      else if (pick < 94) push_req(REQ_ADD, rand_word(), rand_word(), 5'($urandom));
      else push_req(REQ_ADD, rand_word(), 32'($urandom_range(0, 3)), 5'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int k;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    req_type = REQ_NONE;
    range_start = '0;
    range_length = '0;
    entry_index = '0;
    tbl_count = 0;
    mismatches = 0;
    sent_count = 0;
    got_count = 0;
    idle_cycles = 0;
    idling_on = 1'b1;
    rx_hold = 1'b0;
    rx_hold_done = 1'b0;
    tx_pause = 1'b0;
    done_stim = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, every request type, overflow, zero length, touching
    push_req(REQ_READ, 32'h0, 32'h0, 5'd0);
    push_req(REQ_ADD, 32'd100, 32'd10, 5'd31);
    push_req(REQ_ADD, 32'd110, 32'd0, 5'd0);
    push_req(REQ_ADD, 32'd90, 32'd10, 5'd0);
    push_req(REQ_ADD, 32'd200, 32'd5, 5'd0);
    push_req(REQ_ADD, 32'd120, 32'd80, 5'd0);
    push_req(REQ_ADD, 32'hFFFFFFFF, 32'h1, 5'd0);
    push_req(REQ_ADD, 32'h1, 32'hFFFFFFFF, 5'd0);
    push_req(REQ_ADD, 32'hFFFFFFFF, 32'h0, 5'd0);
    push_req(REQ_ADD, 32'h0, 32'hFFFFFFFF, 5'd0);
    push_req(REQ_READ, 32'hFFFFFFFF, 32'hFFFFFFFF, 5'd0);
    push_req(REQ_READ, 32'h0, 32'h0, 5'd31);
    push_req(REQ_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 5'd31);
    push_req(REQ_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 5'd31);
    push_req(REQ_ADD, 32'd50, 32'd0, 5'd0);
    push_req(REQ_ADD, 32'd50, 32'd3, 5'd0);
    push_req(REQ_READ, 32'h0, 32'h0, 5'd1);
    // fill past capacity with disjoint ranges, then read the last slot
    for (k = 0; k < CAP + 2; k++) push_req(REQ_ADD, 32'(1000 + 10 * k), 32'd2, 5'd0);
    push_req(REQ_READ, 32'h0, 32'h0, 5'd31);
    // a bridging add that collapses several entries
    push_req(REQ_ADD, 32'd1001, 32'd50, 5'd0);
    wait_drained();

    // sender pauses until every result is in, then random traffic
    tx_pause = 1'b1;
    wait_drained();
    repeat (CAP + 8) @(negedge clk);
    tx_pause = 1'b0;
    queue_random(300, 32'h0);

    // long receiver hold while the sender keeps offering
    rx_hold = 1'b1;
    queue_random(20, 32'h8000_0000);
    wait (rx_hold_done);
    rx_hold = 1'b0;
    queue_random(280, 32'hFFFF_F000 - 32'd2100);

    wait_drained();
    // last stretch runs at full rate on both sides
    idling_on = 1'b0;
    queue_random(300, 32'h0040_0000);
    wait_drained();
    repeat (CAP + 8) @(negedge clk);

    $display("covered %0d requests and %0d results: adds with merges, overflow, full table,",
             sent_count, got_count);
    $display("reads with bad indexes, clears, unknown requests, stalls on both sides");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
sv/vris_pkg.sv
sv/vris_bank.sv
sv/vris_engine.sv
sv/valid_range_interval_set_top.sv
test/valid_range_interval_set_top_tb.sv
